// ===== rtl/crqs_pkg.sv =====
// Shared types, codes and helpers for the CPU ready-queue scheduler.
package crqs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    typedef enum logic [2:0] {
        EV_ACCEPT = 3'd0,
        EV_REJECT = 3'd1,
        EV_START  = 3'd2,
        EV_RESUME = 3'd3,
        EV_STOP   = 3'd4,
        EV_FINISH = 3'd5
    } event_t;

    localparam logic [1:0] POL_RR     = 2'd0;
    localparam logic [1:0] POL_SRT    = 2'd1;
    localparam logic [1:0] POL_PRIO   = 2'd2;
    localparam logic [1:0] POL_RR_ALT = 2'd3;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    localparam logic [1:0]  POLICY_RESET  = POL_RR;
    localparam logic [15:0] QUANTUM_RESET = 16'd2;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] remaining;
        logic [7:0]  prio;
        logic [31:0] arrival;
        logic [31:0] first_start;
        logic        has_run;
    } slot_t;

    typedef struct packed {
        event_t      kind;
        logic [15:0] task_id;
        logic [31:0] ev_time;
        logic [31:0] wait_ticks;
        logic [31:0] turnaround;
        logic [15:0] remaining;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  policy;
        logic [15:0] quantum;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJ,
        ST_ARR_PRE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS,
        ST_TICK_HEAD,
        ST_DSP_RD,
        ST_DSP
    } state_t;

    function automatic logic [31:0] sat_diff(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? (a - b) : 32'd0;
    endfunction

endpackage

// ===== rtl/crqs_if.sv =====
// Item channel interfaces: task actions in, scheduler events out.
interface crqs_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] task_id;
    logic [15:0] burst_length;
    logic [7:0]  task_priority;
    logic [31:0] arrival_stamp;

    modport source (output valid, action, task_id, burst_length, task_priority,
                    arrival_stamp, input ready);
    modport sink   (input valid, action, task_id, burst_length, task_priority,
                    arrival_stamp, output ready);
endinterface

interface crqs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [15:0] event_task;
    logic [31:0] event_time;
    logic [31:0] wait_ticks;
    logic [31:0] turnaround_ticks;
    logic [15:0] remaining_ticks;
    logic        last_event;

    modport source (output valid, event_kind, event_task, event_time, wait_ticks,
                    turnaround_ticks, remaining_ticks, last_event, input ready);
    modport sink   (input valid, event_kind, event_task, event_time, wait_ticks,
                    turnaround_ticks, remaining_ticks, last_event, output ready);
endinterface

// ===== rtl/crqs_table.sv =====
// Ready table storage: one write port, one registered read port.
module crqs_table #(
    parameter int DEPTH = crqs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int PW    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [PW-1:0]         wr_addr,
    input  crqs_pkg::slot_t       wr_data,
    input  logic                  rd_en,
    input  logic [PW-1:0]         rd_addr,
    output crqs_pkg::slot_t       rd_data
);
    import crqs_pkg::*;

    slot_t mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/crqs_ctrl.sv =====
// Scheduler sequencer: table walks, tick accounting, event output register.
module crqs_ctrl #(
    parameter int DEPTH = crqs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int PW    = $clog2(DEPTH),
    parameter int OW    = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  crqs_pkg::cfg_t        cfg,
    crqs_in_if.sink               in_ch,
    crqs_out_if.source            out_ch,
    output logic                  rd_en,
    output logic [PW-1:0]         rd_addr,
    input  crqs_pkg::slot_t       rd_data,
    output logic                  wr_en,
    output logic [PW-1:0]         wr_addr,
    output crqs_pkg::slot_t       wr_data
);
    import crqs_pkg::*;

    localparam int SW = PW + 2;
    localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

    state_t        state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic          busy_reg, busy_next;
    logic [15:0]   slice_reg, slice_next;
    logic [31:0]   tick_reg, tick_next;
    logic [15:0]   id_reg, id_next;
    logic [15:0]   burst_reg, burst_next;
    logic [7:0]    prio_reg, prio_next;
    logic [31:0]   arr_reg, arr_next;
    logic [OW-1:0] j_reg, j_next;
    logic [OW-1:0] pos_reg, pos_next;
    result_t       out_reg;
    logic          ovalid_reg;
    logic          emit_en;
    result_t       emit;

    // logical slot -> physical address, circular around head
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [OW-1:0] l);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(l);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] head_inc(input logic [PW-1:0] h);
        return (SW'(h) == SW'(DEPTH - 1)) ? '0 : h + PW'(1);
    endfunction

    slot_t       cur;
    slot_t       upd;
    logic        out_free;
    logic [15:0] in_burst;
    logic [15:0] q;
    logic [15:0] rem_dec;
    logic [15:0] slice_inc;
    logic        rr_pol;
    logic        preempt;
    logic        srch_go;
    logic        tk_finish;
    logic        tk_rotate;

    assign cur       = rd_data;
    assign out_free  = !ovalid_reg || out_ch.ready;
    assign in_burst  = (in_ch.burst_length == 16'd0) ? 16'd1 : in_ch.burst_length;
    assign q         = (cfg.quantum == 16'd0) ? 16'd1 : cfg.quantum;
    assign rem_dec   = (cur.remaining == 16'd0) ? 16'd0 : cur.remaining - 16'd1;
    assign slice_inc = (slice_reg == 16'hFFFF) ? slice_reg : slice_reg + 16'd1;
    assign rr_pol    = (cfg.policy == POL_RR) || (cfg.policy == POL_RR_ALT);
    assign preempt   = (cur.remaining == 16'd0) || (rem_dec > burst_reg);
    assign srch_go   = (cfg.policy == POL_SRT) ? (cur.remaining < burst_reg)
                                               : (prio_reg > cur.prio);
    assign tk_finish = (rem_dec == 16'd0);
    assign tk_rotate = rr_pol && (slice_inc >= q);
    assign in_ch.ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.action)
                    begin
                        state_next = (busy_reg && occ_reg != '0) ? ST_TICK_HEAD : ST_DSP_RD;
                    end
                    else if (occ_reg >= DEPTH_O)
                    begin
                        state_next = ST_REJ;
                    end
                    else if (occ_reg == '0)
                    begin
                        state_next = ST_INS;
                    end
                    else if (cfg.policy == POL_SRT && busy_reg)
                    begin
                        state_next = ST_ARR_PRE;
                    end
                    else if (cfg.policy == POL_SRT || cfg.policy == POL_PRIO)
                    begin
                        state_next = ST_SRCH_RD;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
            end
            ST_REJ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ARR_PRE:
            begin
                if (!preempt)
                begin
                    state_next = ST_SRCH_RD;
                end
                else if (out_free)
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SRCH_RD:
            begin
                state_next = (j_reg >= occ_reg) ? ST_SHIFT_RD : ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                state_next = srch_go ? ST_SRCH_RD : ST_SHIFT_RD;
            end
            ST_SHIFT_RD:
            begin
                state_next = (j_reg > pos_reg) ? ST_SHIFT_WR : ST_INS;
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_INS:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_HEAD:
            begin
                if (!tk_finish && !tk_rotate)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    state_next = ST_DSP_RD;
                end
            end
            ST_DSP_RD:
            begin
                state_next = (occ_reg != '0) ? ST_DSP : ST_IDLE;
            end
            ST_DSP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next  = head_reg;
        occ_next   = occ_reg;
        busy_next  = busy_reg;
        slice_next = slice_reg;
        tick_next  = tick_reg;
        id_next    = id_reg;
        burst_next = burst_reg;
        prio_next  = prio_reg;
        arr_next   = arr_reg;
        j_next     = j_reg;
        pos_next   = pos_reg;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_data    = cur;
        emit_en    = 1'b0;
        emit       = '0;
        upd        = cur;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    id_next    = in_ch.task_id;
                    burst_next = in_burst;
                    prio_next  = in_ch.task_priority;
                    arr_next   = in_ch.arrival_stamp;
                    if (in_ch.action)
                    begin
                        if (busy_reg && occ_reg != '0)
                        begin
                            rd_en = 1'b1;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                        end
                    end
                    else if (occ_reg < DEPTH_O)
                    begin
                        if (occ_reg == '0)
                        begin
                            pos_next = '0;
                        end
                        else if (cfg.policy == POL_SRT && busy_reg)
                        begin
                            rd_en = 1'b1;
                        end
                        else if (cfg.policy == POL_SRT || cfg.policy == POL_PRIO)
                        begin
                            j_next = busy_reg ? OW'(1) : '0;
                        end
                        else
                        begin
                            pos_next = occ_reg;
                            j_next   = occ_reg;
                        end
                    end
                end
            end
            ST_REJ:
            begin
                if (out_free)
                begin
                    emit_en        = 1'b1;
                    emit.kind      = EV_REJECT;
                    emit.task_id   = id_reg;
                    emit.ev_time   = tick_reg;
                    emit.remaining = burst_reg;
                    emit.last      = 1'b1;
                end
            end
            ST_ARR_PRE:
            begin
                // running task is charged one unit before the preemption check
                upd.remaining = rem_dec;
                if (!preempt)
                begin
                    j_next = OW'(1);
                end
                else if (out_free)
                begin
                    wr_en           = 1'b1;
                    wr_data         = upd;
                    emit_en         = 1'b1;
                    emit.kind       = EV_STOP;
                    emit.task_id    = cur.task_id;
                    emit.ev_time    = tick_reg;
                    emit.wait_ticks = cur.has_run ? sat_diff(cur.first_start, cur.arrival)
                                                  : 32'd0;
                    emit.remaining  = rem_dec;
                    busy_next       = 1'b0;
                    pos_next        = '0;
                    j_next          = occ_reg;
                end
            end
            ST_SRCH_RD:
            begin
                if (j_reg >= occ_reg)
                begin
                    pos_next = j_reg;
                    j_next   = occ_reg;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = phys(head_reg, j_reg);
                end
            end
            ST_SRCH_CMP:
            begin
                if (srch_go)
                begin
                    j_next = j_reg + OW'(1);
                end
                else
                begin
                    pos_next = j_reg;
                    j_next   = occ_reg;
                end
            end
            ST_SHIFT_RD:
            begin
                if (j_reg > pos_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = phys(head_reg, j_reg - OW'(1));
                end
            end
            ST_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, j_reg);
                wr_data = cur;
                j_next  = j_reg - OW'(1);
            end
            ST_INS:
            begin
                if (out_free)
                begin
                    wr_en               = 1'b1;
                    wr_addr             = phys(head_reg, pos_reg);
                    wr_data.task_id     = id_reg;
                    wr_data.remaining   = burst_reg;
                    wr_data.prio        = prio_reg;
                    wr_data.arrival     = arr_reg;
                    wr_data.first_start = 32'd0;
                    wr_data.has_run     = 1'b0;
                    occ_next            = occ_reg + OW'(1);
                    emit_en             = 1'b1;
                    emit.kind           = EV_ACCEPT;
                    emit.task_id        = id_reg;
                    emit.ev_time        = tick_reg;
                    emit.remaining      = burst_reg;
                    emit.last           = 1'b1;
                end
            end
            ST_TICK_HEAD:
            begin
                upd.remaining   = rem_dec;
                emit.task_id    = cur.task_id;
                emit.ev_time    = tick_reg;
                emit.wait_ticks = cur.has_run ? sat_diff(cur.first_start, cur.arrival) : 32'd0;
                emit.remaining  = rem_dec;
                if (tk_finish)
                begin
                    if (out_free)
                    begin
                        emit_en         = 1'b1;
                        emit.kind       = EV_FINISH;
                        emit.turnaround = sat_diff(tick_reg, cur.arrival);
                        emit.last       = (occ_reg == OW'(1));
                        head_next       = head_inc(head_reg);
                        occ_next        = occ_reg - OW'(1);
                        busy_next       = 1'b0;
                        slice_next      = slice_inc;
                    end
                end
                else if (tk_rotate)
                begin
                    if (out_free)
                    begin
                        // head moves to the tail slot, then the ring advances
                        emit_en    = 1'b1;
                        emit.kind  = EV_STOP;
                        wr_en      = 1'b1;
                        wr_addr    = phys(head_reg, occ_reg);
                        wr_data    = upd;
                        head_next  = head_inc(head_reg);
                        busy_next  = 1'b0;
                        slice_next = slice_inc;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = upd;
                    slice_next = slice_inc;
                    tick_next  = tick_reg + 32'd1;
                end
            end
            ST_DSP_RD:
            begin
                if (occ_reg != '0)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    tick_next = tick_reg + 32'd1;
                end
            end
            ST_DSP:
            begin
                if (!cur.has_run)
                begin
                    upd.has_run     = 1'b1;
                    upd.first_start = tick_reg;
                end
                if (out_free)
                begin
                    wr_en           = 1'b1;
                    wr_data         = upd;
                    emit_en         = 1'b1;
                    emit.kind       = cur.has_run ? EV_RESUME : EV_START;
                    emit.task_id    = cur.task_id;
                    emit.ev_time    = tick_reg;
                    emit.wait_ticks = sat_diff(upd.first_start, upd.arrival);
                    emit.remaining  = cur.remaining;
                    emit.last       = 1'b1;
                    busy_next       = 1'b1;
                    slice_next      = 16'd0;
                    tick_next       = tick_reg + 32'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            occ_reg    <= '0;
            busy_reg   <= 1'b0;
            slice_reg  <= '0;
            tick_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
            busy_reg  <= busy_next;
            slice_reg <= slice_next;
            tick_reg  <= tick_next;
            if (emit_en)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        burst_reg <= burst_next;
        prio_reg  <= prio_next;
        arr_reg   <= arr_next;
        j_reg     <= j_next;
        pos_reg   <= pos_next;
        if (emit_en)
        begin
            out_reg <= emit;
        end
    end

    assign out_ch.valid            = ovalid_reg;
    assign out_ch.event_kind       = out_reg.kind;
    assign out_ch.event_task       = out_reg.task_id;
    assign out_ch.event_time       = out_reg.ev_time;
    assign out_ch.wait_ticks       = out_reg.wait_ticks;
    assign out_ch.turnaround_ticks = out_reg.turnaround;
    assign out_ch.remaining_ticks  = out_reg.remaining;
    assign out_ch.last_event       = out_reg.last;
endmodule

// ===== rtl/cpu_ready_queue_scheduler.sv =====
// Top level of the CPU ready-queue scheduler: config registers, table, sequencer.
// Tasks live in a circular ready table held in one synchronous RAM; slot 0 is
// the running task. Under round robin an arrival is appended at the tail, and under
// the sorted policies its slot is found by a search walk that reads and compares
// one entry at a time, then later entries shift through the single RAM read port.
// Results sit in an output register, so a new item is taken while the last result
// waits; an item's later results wait for the register to drain. No clearing pass
// is needed after reset.
module cpu_ready_queue_scheduler #(
    parameter int TABLE_DEPTH = crqs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    crqs_in_if.sink     in_ch,
    crqs_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import crqs_pkg::*;

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int OW = $clog2(TABLE_DEPTH + 1);

    cfg_t          cfg_reg;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    slot_t         rd_data;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    slot_t         wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy  <= POLICY_RESET;
            cfg_reg.quantum <= QUANTUM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLICY:  cfg_reg.policy  <= cfg_data[1:0];
                REG_QUANTUM: cfg_reg.quantum <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    crqs_table #(
        .DEPTH (TABLE_DEPTH),
        .PW    (PW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crqs_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .PW    (PW),
        .OW    (OW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );
endmodule
